### rtl/spsm_pkg.sv
// ----------------------------------------------------------------------------
// spsm_pkg
// Types and constants shared by the sample player and stereo mixer.
// ----------------------------------------------------------------------------
`default_nettype none
package spsm_pkg;

  localparam int CmdW   = 3;
  localparam int ChanW  = 3;
  localparam int LevelW = 8;
  localparam int AddrW  = 16;
  localparam int CountW = 17;
  localparam int WordW  = 16;

  // Sample memory depth, one word per address
  localparam int MemWords = 65536;

  localparam logic [CmdW-1:0] CMD_TICK    = 3'd0;
  localparam logic [CmdW-1:0] CMD_TRIGGER = 3'd1;
  localparam logic [CmdW-1:0] CMD_PAN     = 3'd2;
  localparam logic [CmdW-1:0] CMD_VOLUME  = 3'd3;
  localparam logic [CmdW-1:0] CMD_SAMPLE  = 3'd4;
  localparam logic [CmdW-1:0] CMD_WRITE   = 3'd5;

  localparam logic [LevelW-1:0] PAN_CENTRE = 8'd128;
  localparam logic [LevelW-1:0] VOL_FULL   = 8'd255;
  localparam logic signed [WordW-1:0] SAT_MAX = 16'sd32767;
  localparam logic signed [WordW-1:0] SAT_MIN = -16'sd32768;

  // Product widths along the scaling chain
  localparam int ProdW = 26;
  localparam int AccW  = 24;

  typedef struct packed {
    logic [CmdW-1:0]          command;
    logic [ChanW-1:0]         channel;
    logic [LevelW-1:0]        level;
    logic [AddrW-1:0]         address;
    logic [CountW-1:0]        sample_count;
    logic signed [WordW-1:0]  write_value;
  } in_item_t;

  typedef struct packed {
    logic signed [WordW-1:0] left_out;
    logic signed [WordW-1:0] right_out;
  } out_item_t;

  // Operands handed to the bit-serial multiplier
  typedef struct packed {
    logic                     start;
    logic signed [ProdW-1:0]  mcand;
    logic [LevelW-1:0]        mplier;
  } mul_req_t;

  typedef struct packed {
    logic                     done;
    logic signed [ProdW-1:0]  product;
  } mul_rsp_t;

endpackage
`default_nettype wire

### rtl/spsm_serial_mul.sv
// ----------------------------------------------------------------------------
// spsm_serial_mul
// Shift-and-add multiplier: signed multiplicand by 8-bit unsigned multiplier,
// one multiplier bit per cycle.
// ----------------------------------------------------------------------------
`default_nettype none
module spsm_serial_mul (
  input  wire                  clk,
  input  wire                  rst_n,
  input  wire spsm_pkg::mul_req_t req,
  output spsm_pkg::mul_rsp_t   rsp
);
  import spsm_pkg::*;

  logic signed [ProdW-1:0] acc_r, acc_nxt;
  logic signed [ProdW-1:0] mcand_r, mcand_nxt;
  logic [LevelW-1:0]       mplier_r, mplier_nxt;
  logic [3:0]              cnt_r, cnt_nxt;
  logic                    busy_r, busy_nxt;
  logic                    done_r, done_nxt;

  always_comb begin
    acc_nxt    = acc_r;
    mcand_nxt  = mcand_r;
    mplier_nxt = mplier_r;
    cnt_nxt    = cnt_r;
    busy_nxt   = busy_r;
    done_nxt   = 1'b0;
    if (req.start) begin
      acc_nxt    = '0;
      mcand_nxt  = req.mcand;
      mplier_nxt = req.mplier;
      cnt_nxt    = 4'd0;
      busy_nxt   = 1'b1;
    end else if (busy_r) begin
      if (mplier_r[0]) acc_nxt = acc_r + mcand_r;
      mcand_nxt  = mcand_r <<< 1;
      mplier_nxt = mplier_r >> 1;
      cnt_nxt    = cnt_r + 4'd1;
      if (cnt_r == 4'(LevelW - 1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
    acc_r    <= acc_nxt;
    mcand_r  <= mcand_nxt;
    mplier_r <= mplier_nxt;
  end

  assign rsp.done    = done_r;
  assign rsp.product = acc_r;

endmodule
`default_nettype wire

### rtl/sample_playback_stereo_mixer.sv
// A tick's result reaches out_data after every channel has passed through the
//   channel states and then the SAT and OUT states; any other command is taken
//   without stalling the input. One item at a time.
// Each playing channel needs a memory read and four serial multiplies
//   (velocity, volume, left pan, right pan); a waiting result holds the next.
// Reset returns all channel state to defaults (volume full, pan centre); the sample memory is undefined until written.
// ----------------------------------------------------------------------------
// sample_playback_stereo_mixer
// Sample player with stereo pan mixer, channels processed in turn.
// ----------------------------------------------------------------------------
`default_nettype none
module sample_playback_stereo_mixer #(
  parameter int CHANNELS     = 8
) (
  input  wire                   clk,
  input  wire                   rst_n,
  input  wire                   in_valid,
  output logic                  in_stall,
  input  wire spsm_pkg::in_item_t in_data,
  output logic                  out_valid,
  input  wire                   out_stall,
  output spsm_pkg::out_item_t   out_data
);
  import spsm_pkg::*;

  localparam int MemAw = $clog2(MemWords);
  localparam int ChIdxW = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;

  typedef enum logic [8:0] {
    ST_IDLE  = 9'b000000001,
    ST_CHAN  = 9'b000000010,
    ST_READ  = 9'b000000100,
    ST_VEL   = 9'b000001000,
    ST_VOL   = 9'b000010000,
    ST_LEFT  = 9'b000100000,
    ST_RIGHT = 9'b001000000,
    ST_SAT   = 9'b010000000,
    ST_OUT   = 9'b100000000
  } state_t;

  state_t state_r, state_nxt;

  logic [WordW-1:0] mem [MemWords];
  logic [WordW-1:0] rd_r;

  logic [AddrW-1:0]  start_r  [CHANNELS];
  logic [CountW-1:0] size_r   [CHANNELS];
  logic [CountW-1:0] offs_r   [CHANNELS];
  logic [LevelW-1:0] vel_r    [CHANNELS];
  logic [LevelW-1:0] vol_r    [CHANNELS];
  logic [LevelW-1:0] pan_r    [CHANNELS];
  logic [CHANNELS-1:0] play_r, has_r;

  logic [ChIdxW:0]          ch_r, ch_nxt;
  logic [ChIdxW-1:0]        ci;
  logic signed [AccW-1:0]   left_r, left_nxt, right_r, right_nxt;
  logic signed [ProdW-1:0]  s_r, s_nxt;
  out_item_t                out_r;
  logic                     out_valid_r;

  mul_req_t mreq;
  mul_rsp_t mrsp;

  spsm_serial_mul u_mul (.clk(clk), .rst_n(rst_n), .req(mreq), .rsp(mrsp));

  assign ci = ch_r[ChIdxW-1:0];

  logic active;
  assign active = play_r[ci] && (offs_r[ci] < size_r[ci]);

  logic [MemAw-1:0] rd_addr;
  logic [CountW:0]  rd_sum;
  assign rd_sum  = (CountW+1)'(start_r[ci]) + (CountW+1)'(offs_r[ci]);
  assign rd_addr = MemAw'(rd_sum);

  logic [MemAw-1:0] wr_addr;
  assign wr_addr = MemAw'(in_data.address);

  logic take;
  assign in_stall = (state_r != ST_IDLE);
  assign take     = in_valid && !in_stall;
  logic cmd_ok;
  assign cmd_ok = (32'(in_data.channel) < CHANNELS);
  logic [ChIdxW-1:0] ic;
  assign ic = ChIdxW'(in_data.channel);

  logic out_load;
  assign out_load = (state_r == ST_OUT) && (state_nxt == ST_IDLE);

  function automatic logic signed [AccW-1:0] sat(input logic signed [AccW-1:0] x);
    if (x > AccW'(SAT_MAX)) return AccW'(SAT_MAX);
    if (x < AccW'(SAT_MIN)) return AccW'(SAT_MIN);
    return x;
  endfunction

  always_comb begin
    state_nxt    = state_r;
    ch_nxt       = ch_r;
    left_nxt     = left_r;
    right_nxt    = right_r;
    s_nxt        = s_r;
    mreq         = '0;
    case (state_r)
      ST_IDLE: begin
        if (take && in_data.command == CMD_TICK) begin
          state_nxt = ST_CHAN;
          ch_nxt    = '0;
          left_nxt  = '0;
          right_nxt = '0;
        end
      end
      ST_CHAN: begin
        if (32'(ch_r) >= CHANNELS) state_nxt = ST_SAT;
        else if (active) state_nxt = ST_READ;
        else ch_nxt = ch_r + 1'b1;
      end
      ST_READ: begin
        mreq.start  = 1'b1;
        mreq.mcand  = ProdW'($signed(rd_r));
        mreq.mplier = vel_r[ci];
        state_nxt   = ST_VEL;
      end
      ST_VEL: begin
        if (mrsp.done) begin
          mreq.start  = 1'b1;
          mreq.mcand  = mrsp.product >>> 8;
          mreq.mplier = vol_r[ci];
          state_nxt   = ST_VOL;
        end
      end
      ST_VOL: begin
        if (mrsp.done) begin
          s_nxt       = mrsp.product >>> 8;
          mreq.start  = 1'b1;
          mreq.mcand  = mrsp.product >>> 8;
          mreq.mplier = VOL_FULL - pan_r[ci];
          state_nxt   = ST_LEFT;
        end
      end
      ST_LEFT: begin
        if (mrsp.done) begin
          left_nxt    = left_r + AccW'(mrsp.product >>> 7);
          mreq.start  = 1'b1;
          mreq.mcand  = s_r;
          mreq.mplier = pan_r[ci];
          state_nxt   = ST_RIGHT;
        end
      end
      ST_RIGHT: begin
        if (mrsp.done) begin
          right_nxt = right_r + AccW'(mrsp.product >>> 7);
          ch_nxt    = ch_r + 1'b1;
          state_nxt = ST_CHAN;
        end
      end
      ST_SAT: state_nxt = ST_OUT;
      ST_OUT: if (!out_valid_r || !out_stall) state_nxt = ST_IDLE;
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (take && in_data.command == CMD_WRITE) mem[wr_addr] <= in_data.write_value;
    rd_r <= mem[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      ch_r        <= '0;
      out_valid_r <= 1'b0;
      play_r      <= '0;
      has_r       <= '0;
      for (int i = 0; i < CHANNELS; i++) begin
        start_r[i] <= '0;
        size_r[i]  <= '0;
        offs_r[i]  <= '0;
        vel_r[i]   <= '0;
        vol_r[i]   <= VOL_FULL;
        pan_r[i]   <= PAN_CENTRE;
      end
    end else begin
      state_r <= state_nxt;
      ch_r    <= ch_nxt;
      if (out_load) out_valid_r <= 1'b1;
      else if (out_valid_r && !out_stall) out_valid_r <= 1'b0;
      if (state_r == ST_RIGHT && mrsp.done) begin
        offs_r[ci] <= offs_r[ci] + 1'b1;
        if (offs_r[ci] + 1'b1 >= size_r[ci]) play_r[ci] <= 1'b0;
      end
      if (take && cmd_ok) begin
        case (in_data.command)
          CMD_TRIGGER: if (has_r[ic]) begin
            offs_r[ic] <= '0;
            vel_r[ic]  <= in_data.level;
            play_r[ic] <= 1'b1;
          end
          CMD_PAN:    pan_r[ic] <= in_data.level;
          CMD_VOLUME: vol_r[ic] <= in_data.level;
          CMD_SAMPLE: begin
            start_r[ic] <= in_data.address;
            size_r[ic]  <= in_data.sample_count;
            offs_r[ic]  <= '0;
            play_r[ic]  <= 1'b0;
            has_r[ic]   <= 1'b1;
            if (pan_r[ic] == '0 && pan_r[ChIdxW'(0)] == '0) pan_r[ic] <= PAN_CENTRE;
          end
          default: ;
        endcase
      end
    end
    left_r  <= left_nxt;
    right_r <= right_nxt;
    s_r     <= s_nxt;
    if (out_load) begin
      out_r.left_out  <= WordW'(sat(left_r));
      out_r.right_out <= WordW'(sat(right_r));
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_r;

endmodule
`default_nettype wire

### rtl/spsm_checker.sv
// ----------------------------------------------------------------------------
// spsm_assertions
// Port-level checks for the sample player, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none
module spsm_assertions (
  input wire                  clk,
  input wire                  rst_n,
  input wire                  in_valid,
  input wire                  in_stall,
  input wire spsm_pkg::in_item_t  in_data,
  input wire                  out_valid,
  input wire                  out_stall,
  input wire spsm_pkg::out_item_t out_data
);
  import spsm_pkg::*;

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_data))
    else $error("stalled item changed");

  a_nontick_no_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall && in_data.command != CMD_TICK |=> !in_stall)
    else $error("non-tick command stalled input");

  a_tick_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall && in_data.command == CMD_TICK |=> in_stall)
    else $error("tick did not occupy the block");

  a_reset_quiet: assert property (@(posedge clk)
    !rst_n |=> !out_valid && !in_stall)
    else $error("state left after reset");

endmodule

bind sample_playback_stereo_mixer spsm_assertions u_spsm_assertions (
  .clk(clk), .rst_n(rst_n), .in_valid(in_valid), .in_stall(in_stall),
  .in_data(in_data), .out_valid(out_valid), .out_stall(out_stall),
  .out_data(out_data)
);
`default_nettype wire
